### hdl/assert_macros.svh
// assertion helper macros, empty under synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

### hdl/tkpid_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tkpid_pkg
// constants, round table and base64 alphabet for the keyed id generator
// ----------------------------------------------------------------------------
package tkpid_pkg;

  localparam int MaxKeyBytes = 32;
  localparam int KeyLenW     = 6;
  localparam int CfgIdxW     = 3;
  localparam int CfgDataW    = 64;
  localparam int CharW       = 7;
  localparam int NumChars    = 12;
  localparam int RoundW      = 6;
  localparam int NonceBytes  = 3;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_KEY_LENGTH = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_KEY_WORD_0 = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_KEY_WORD_1 = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_KEY_WORD_2 = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_KEY_WORD_3 = 3'd4;

  localparam logic [255:0] INIT_H = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  // round constant table
  function automatic logic [31:0] round_k(input logic [RoundW-1:0] t);
    logic [31:0] k;
    unique case (t)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  // base64 alphabet
  function automatic logic [CharW-1:0] b64_char(input logic [5:0] v);
    logic [CharW-1:0] c;
    if (v < 6'd26)      c = 7'd65 + {1'b0, v};
    else if (v < 6'd52) c = 7'd71 + {1'b0, v};
    else if (v < 6'd62) c = {1'b0, v} - 7'd4;
    else if (v == 6'd62) c = 7'd43;
    else                c = 7'd47;
    return c;
  endfunction

  // handshake between sequencer and round core
  typedef struct packed {
    logic start;
    logic step;
  } core_ctl_t;

endpackage
`default_nettype wire

### hdl/tkpid_round_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tkpid_round_core
// one sha-256 round and one schedule word per cycle while step is high, shared over 64 rounds
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module tkpid_round_core
  import tkpid_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire core_ctl_t       ctl,
  input  wire logic [511:0]    block,
  input  wire logic [RoundW-1:0] round,
  output logic [47:0]          digest_head
);

  logic [31:0] a_r, b_r, c_r, d_r, e_r, f_r, g_r, h_r;
  logic [31:0] w_r [16];
  logic [31:0] s0w, s1w, wnew, s1, ch, s0, mj, t1, t2;
  logic [31:0] h0_sum, h1_sum;

  // schedule window: w_r[0] is the word for this round
  always_comb begin
    s0w  = {w_r[1][6:0], w_r[1][31:7]} ^ {w_r[1][17:0], w_r[1][31:18]} ^ (w_r[1] >> 3);
    s1w  = {w_r[14][16:0], w_r[14][31:17]} ^ {w_r[14][18:0], w_r[14][31:19]}
         ^ (w_r[14] >> 10);
    wnew = w_r[0] + s0w + w_r[9] + s1w;
    s1   = {e_r[5:0], e_r[31:6]} ^ {e_r[10:0], e_r[31:11]} ^ {e_r[24:0], e_r[31:25]};
    ch   = (e_r & f_r) ^ (~e_r & g_r);
    t1   = h_r + s1 + ch + round_k(round) + w_r[0];
    s0   = {a_r[1:0], a_r[31:2]} ^ {a_r[12:0], a_r[31:13]} ^ {a_r[21:0], a_r[31:22]};
    mj   = (a_r & b_r) ^ (a_r & c_r) ^ (b_r & c_r);
    t2   = s0 + mj;
  end

  // working variables and schedule
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      {a_r, b_r, c_r, d_r, e_r, f_r, g_r, h_r} <= INIT_H;
      for (int i = 0; i < 16; i++) w_r[i] <= block[511-32*i -: 32];
    end else if (ctl.step) begin
      h_r <= g_r; g_r <= f_r; f_r <= e_r; e_r <= d_r + t1;
      d_r <= c_r; c_r <= b_r; b_r <= a_r; a_r <= t1 + t2;
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= wnew;
    end
  end

  // first two digest words, full 32-bit adds
  assign h0_sum      = a_r + INIT_H[255:224];
  assign h1_sum      = b_r + INIT_H[223:192];
  assign digest_head = {h0_sum, h1_sum[31:16]};

  `ASSERT_NEVER(a_start_step, clk, rst_n, ctl.start && ctl.step, "start and step together")

endmodule
`default_nettype wire

### hdl/time_keyed_privacy_id_generator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// time_keyed_privacy_id_generator_unit
// keyed sha-256 over a time nonce, 9-byte id given as 12 base64 characters
// ----------------------------------------------------------------------------
// channel  dir  tdata
// in_      in   time_val[31:0]
// out_     out  text_char_0..11, 7 bits each, char 0 lowest (84 bits)
// cfg_     in   index 0 key_length, 1..4 key_word_0..3
//
// the accepting edge loads the shared round unit; the sequencer then steps
// the rounds, encodes the id into the output register and offers the result.
// the next item is taken the cycle after the result is taken, so a new time
// value is not accepted while an id is still in flight.
// rst_n is synchronous; key_length resets to 32, key words to zero.
// a stalled result holds in the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module time_keyed_privacy_id_generator_unit
  import tkpid_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [31:0]          in_tdata,   // time_val
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [NumChars*CharW-1:0] out_tdata,  // text_char_0 .. text_char_11
  input  wire logic                 cfg_we,
  input  wire logic [CfgIdxW-1:0]   cfg_index,
  input  wire logic [CfgDataW-1:0]  cfg_data
);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE, S_OUT} state_t;

  state_t                   state_r;
  logic [RoundW-1:0]        round_r;
  logic [KeyLenW-1:0]       key_len_r;
  logic [255:0]             key_r;
  logic [23:0]              nonce_r;
  logic [NumChars*CharW-1:0] text_r;
  logic [511:0]             block;
  logic [47:0]              digest_head;
  logic [71:0]              id;
  logic [KeyLenW-1:0]       klen;
  logic [8:0]               bits;
  core_ctl_t                ctl;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_len_r <= KeyLenW'(MaxKeyBytes);
      key_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY_LENGTH: key_len_r <= cfg_data[KeyLenW-1:0];
        REG_KEY_WORD_0: key_r[255:192] <= cfg_data;
        REG_KEY_WORD_1: key_r[191:128] <= cfg_data;
        REG_KEY_WORD_2: key_r[127:64]  <= cfg_data;
        REG_KEY_WORD_3: key_r[63:0]    <= cfg_data;
        default: ;
      endcase
    end
  end

  // message block: nonce, key bytes, pad byte, bit length
  always_comb begin
    klen  = (key_len_r > KeyLenW'(MaxKeyBytes)) ? KeyLenW'(MaxKeyBytes) : key_len_r;
    bits  = 9'((klen + 6'd3) * 8);
    block = '0;
    block[511:488] = {in_tdata[15:8], in_tdata[23:16], in_tdata[31:24]};
    for (int i = 0; i < MaxKeyBytes; i++) begin
      if (i < klen) block[487-8*i -: 8] = key_r[255-8*i -: 8];
      else if (i == klen) block[487-8*i -: 8] = 8'h80;
    end
    if (klen == KeyLenW'(MaxKeyBytes)) block[231:224] = 8'h80;
    block[15:0] = {7'd0, bits};
  end

  assign ctl.start = (state_r == S_IDLE) && in_tvalid;
  assign ctl.step  = (state_r == S_RUN);

  tkpid_round_core u_core (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .block(block),
    .round(round_r), .digest_head(digest_head));

  assign id = {nonce_r, digest_head};

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      round_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: if (in_tvalid) begin
          nonce_r <= {in_tdata[15:8], in_tdata[23:16], in_tdata[31:24]};
          round_r <= '0;
          state_r <= S_RUN;
        end
        S_RUN: begin
          round_r <= round_r + 1'b1;
          if (round_r == '1) state_r <= S_DONE;
        end
        S_DONE: begin
          for (int i = 0; i < NumChars; i++)
            text_r[CharW*i +: CharW] <= b64_char(id[71-6*i -: 6]);
          state_r <= S_OUT;
        end
        S_OUT: if (out_tready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = text_r;

  `ASSERT_NEVER(a_busy_both, clk, rst_n, in_tready && out_tvalid, "ready while result pending")
  `ASSERT_CLK(a_run_exit, clk, rst_n,
    (state_r == S_RUN && round_r == '1) |=> state_r == S_DONE, "round count slip")
  `ASSERT_CLK(a_accept_run, clk, rst_n,
    (in_tvalid && in_tready) |=> (state_r == S_RUN && round_r == '0), "accept not started")

endmodule
`default_nettype wire

### sim/time_keyed_privacy_id_generator_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_keyed_privacy_id_generator_unit_tb
// Drives time values through the keyed id generator and compares every
// 12-character base64 id against a local sha-256 based prediction, across
// several key lengths (including oversized ones) and key settings.
// ----------------------------------------------------------------------------
module time_keyed_privacy_id_generator_unit_tb;
  import tkpid_pkg::*;

  logic                      clk;
  logic                      rst_n;
  logic                      in_tvalid;
  logic                      in_tready;
  logic [31:0]               in_tdata;   // time_val
  logic                      out_tvalid;
  logic                      out_tready;
  logic [NumChars*CharW-1:0] out_tdata;  // text_char_0 .. text_char_11
  logic                      cfg_we;
  logic [CfgIdxW-1:0]        cfg_index;
  logic [CfgDataW-1:0]       cfg_data;

  // index with no register behind it
  localparam logic [CfgIdxW-1:0] REG_UNMAPPED = 3'd7;

  time_keyed_privacy_id_generator_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor copy of the registers
  logic [5:0]  pred_key_len;
  logic [63:0] pred_key [4];

  logic [NumChars*CharW-1:0] id_queue[$];
  int  mismatches;
  int  ids_checked;
  bit  idle_free;   // stretch without idling

  localparam logic [2047:0] K_TAB = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [6:0] to_b64(input logic [5:0] v);
    if (v < 26) return 7'd65 + v;
    else if (v < 52) return 7'(97 + (v - 26));
    else if (v < 62) return 7'(48 + (v - 52));
    else if (v == 62) return 7'd43;
    else return 7'd47;
  endfunction

  // keyed id text for one time value
  function automatic logic [NumChars*CharW-1:0] keyed_id_text(input logic [31:0] tval);
    logic [7:0]  blk [64];
    logic [31:0] w [64];
    logic [31:0] hs [8];
    logic [31:0] a, b, c, d, e, f, g, hh, t1, t2, s0, s1, kk;
    logic [7:0]  idb [9];
    logic [23:0] grp;
    logic [NumChars*CharW-1:0] txt;
    int klen, len;
    logic [10:0] bits;
    for (int i = 0; i < 64; i++) blk[i] = 8'h00;
    blk[0] = tval[15:8]; blk[1] = tval[23:16]; blk[2] = tval[31:24];
    klen = (pred_key_len > 32) ? 32 : pred_key_len;
    len = 3;
    for (int i = 0; i < klen; i++) begin
      blk[len] = pred_key[i / 8][63 - 8 * (i % 8) -: 8];
      len++;
    end
    blk[len] = 8'h80;
    bits = 11'(len * 8);
    blk[62] = {5'b0, bits[10:8]};
    blk[63] = bits[7:0];
    for (int t = 0; t < 16; t++)
      w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
    for (int t = 16; t < 64; t++) begin
      s0 = ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = w[t-16] + s0 + w[t-7] + s1;
    end
    for (int i = 0; i < 8; i++) hs[i] = INIT_H[255 - 32*i -: 32];
    a = hs[0]; b = hs[1]; c = hs[2]; d = hs[3];
    e = hs[4]; f = hs[5]; g = hs[6]; hh = hs[7];
    for (int t = 0; t < 64; t++) begin
      kk = K_TAB[2047 - 32*t -: 32];
      s1 = ror(e, 6) ^ ror(e, 11) ^ ror(e, 25);
      t1 = hh + s1 + ((e & f) ^ (~e & g)) + kk + w[t];
      s0 = ror(a, 2) ^ ror(a, 13) ^ ror(a, 22);
      t2 = s0 + ((a & b) ^ (a & c) ^ (b & c));
      hh = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    hs[0] += a; hs[1] += b;
    idb[0] = blk[0]; idb[1] = blk[1]; idb[2] = blk[2];
    for (int i = 0; i < 6; i++) idb[3+i] = hs[i / 4][31 - 8 * (i % 4) -: 8];
    for (int i = 0; i < 3; i++) begin
      grp = {idb[3*i], idb[3*i+1], idb[3*i+2]};
      txt[(4*i)*CharW +: CharW]   = to_b64(grp[23:18]);
      txt[(4*i+1)*CharW +: CharW] = to_b64(grp[17:12]);
      txt[(4*i+2)*CharW +: CharW] = to_b64(grp[11:6]);
      txt[(4*i+3)*CharW +: CharW] = to_b64(grp[5:0]);
    end
    return txt;
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end

  // result side: random stalls, check each beat
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (id_queue.size() == 0) begin
          $display("%0t unexpected beat: expected none actual %h", $realtime, out_tdata);
          mismatches++;
        end else begin
          logic [NumChars*CharW-1:0] exp_id;
          exp_id = id_queue.pop_front();
          for (int i = 0; i < NumChars; i++)
            if (out_tdata[i*CharW +: CharW] !== exp_id[i*CharW +: CharW]) begin
              $display("%0t char %0d: expected %h actual %h", $realtime, i,
                       exp_id[i*CharW +: CharW], out_tdata[i*CharW +: CharW]);
              mismatches++;
            end
          ids_checked++;
        end
      end
      out_tready <= idle_free || ($urandom_range(99) >= 9);
    end
  end

  // register write, block idle
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_KEY_LENGTH) pred_key_len = val[5:0];
    else if (idx >= REG_KEY_WORD_0 && idx <= REG_KEY_WORD_3) pred_key[idx - 1] = val;
    @(posedge clk);
  endtask

  task automatic drain;
    while (id_queue.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // send one time value
  task automatic send_time(input logic [31:0] tval);
    while (!idle_free && $urandom_range(99) < 9) @(posedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= tval;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    id_queue.push_back(keyed_id_text(tval));
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_reset_key;
    send_time(32'h0000_0000);
    send_time(32'hffff_ffff);
    send_time(32'h1234_56ff);
    drain();
  endtask

  task automatic test_key_lengths;
    int lens [6] = '{0, 1, 31, 32, 33, 63};
    write_reg(REG_KEY_WORD_0, 64'hffff_ffff_ffff_ffff);
    write_reg(REG_KEY_WORD_1, 64'h0123_4567_89ab_cdef);
    write_reg(REG_KEY_WORD_2, 64'h0);
    write_reg(REG_KEY_WORD_3, 64'hfedc_ba98_7654_3210);
    write_reg(REG_UNMAPPED, 64'h1);  // unknown index, ignored
    foreach (lens[i]) begin
      write_reg(REG_KEY_LENGTH, 64'(lens[i]));
      send_time(32'h0000_00aa);
      send_time(32'hffff_ff00);
      send_time($urandom);
      drain();
    end
  endtask

  task automatic test_random;
    for (int ph = 0; ph < 9; ph++) begin
      write_reg(REG_KEY_LENGTH,
                64'((ph == 0) ? 32 : (ph == 1) ? 0 : $urandom_range(63)));
      for (int k = 0; k < 4; k++)
        write_reg(CfgIdxW'(REG_KEY_WORD_0 + k), (ph == 2) ? '1 : {$urandom, $urandom});
      idle_free = (ph == 4);
      for (int n = 0; n < 150; n++) begin
        send_time($urandom);
        // sender holds off until all ids are back
        if (n == 75) while (id_queue.size() != 0) @(posedge clk);
      end
      idle_free = 1'b0;
      drain();
    end
  endtask

  initial begin
    mismatches = 0; ids_checked = 0; idle_free = 1'b0;
    rst_n = 1'b0; in_tvalid = 1'b0; in_tdata = '0;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    pred_key_len = 6'd32;
    for (int i = 0; i < 4; i++) pred_key[i] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_key();
    test_key_lengths();
    test_random();
    $display("covered %0d ids over key lengths 0..63 and random keys", ids_checked);
    if (mismatches == 0 && id_queue.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### time_keyed_privacy_id_generator_unit.f
+incdir+hdl
hdl/tkpid_pkg.sv
hdl/tkpid_round_core.sv
hdl/time_keyed_privacy_id_generator_unit.sv
sim/time_keyed_privacy_id_generator_unit_tb.sv
